// ===== src/vpfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpfd_pkg
// Shared widths, event and result codes for the vector pipe forwarding block.
// ----------------------------------------------------------------------------
package vpfd_pkg;

    // coordinate and port widths
    localparam int COORD_W    = 16;
    localparam int S_TDATA_W  = 176;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 160;
    localparam int M_TUSER_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // shared arithmetic unit widths
    localparam int MUL_W      = 35;
    localparam int DIV_NUM_W  = 100;
    localparam int DIV_DEN_W  = 66;
    localparam int SQ_IN_W    = 68;

    // speed of sound used in the wait time
    localparam int SOUND_SPEED = 1500;

    // event kinds
    localparam logic [1:0] KIND_ORIG  = 2'd0;
    localparam logic [1:0] KIND_RX    = 2'd1;
    localparam logic [1:0] KIND_TIMER = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd6;

    typedef enum logic [2:0] {
        ACT_DELIVER = 3'd0,
        ACT_DROP    = 3'd1,
        ACT_HOLD    = 3'd2,
        ACT_FORWARD = 3'd3,
        ACT_ORIG    = 3'd4,
        ACT_DEFER   = 3'd5,
        ACT_COPY    = 3'd6,
        ACT_IGNORE  = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ACK_NONE = 2'd0,
        ACK_YES  = 2'd1,
        ACK_NO   = 2'd2
    } ack_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WAIT   = 2'd1,
        PH_REEVAL = 2'd2
    } phase_t;

endpackage

// ===== src/vpfd_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpfd_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module vpfd_mul #(
    parameter int W = 35
) (
    input  logic                  aclk,
    input  logic signed [W-1:0]   op_a,
    input  logic signed [W-1:0]   op_b,
    output logic signed [2*W-1:0] prod
);

    logic signed [2*W-1:0] prod_reg;

    // one product per cycle
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ===== src/vpfd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpfd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vpfd_div #(
    parameter int NUM_W = 100,
    parameter int DEN_W = 66
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    // shift in the next numerator bit and trial subtract
    always_comb begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = shifted - {1'b0, den_reg};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== src/vpfd_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpfd_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module vpfd_sqrt #(
    parameter int IN_W = 68
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [IN_W-1:0]   rad_in,
    output logic              done,
    output logic [IN_W/2-1:0] root
);

    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [IN_W-1:0]   x_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W+1:0]  r4;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              fits;

    // bring down two bits and test the next root bit
    always_comb begin
        r4    = {rem_reg, x_reg[IN_W-1 -: 2]};
        trial = (REM_W + 2)'({root_reg, 2'b01});
        diff  = r4 - trial;
        fits  = r4 >= trial;
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= rad_in;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= {x_reg[IN_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[REM_W-1:0] : r4[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== src/vector_pipe_forward_decision.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_pipe_forward_decision
// Forwarding decision of one node in vector-based underwater routing.
// ----------------------------------------------------------------------------
// One event word is taken when the block is idle and gives exactly one result
// word. A received header that needs the geometric tests issues 32 products
// on one shared 35x35 multiplier, then the decision. A header that is held
// then uses the shared restoring divider (up to three divisions) and the shared
// square-root unit (up to four roots) for its wait time. A finished result waits
// in the output register while the next event word is accepted.
module vector_pipe_forward_decision #(
    parameter int REACH          = 1000,
    parameter int DEFAULT_RANGE  = 800,
    parameter int DEFAULT_RADIUS = 350
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [vpfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vpfd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // event words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // src_x, src_y, src_z, dst_x, dst_y, dst_z, hop_x, hop_y, hop_z,
    // near_range, pipe_radius
    input  logic [vpfd_pkg::S_TDATA_W-1:0]      s_tdata,
    // kind
    input  logic [vpfd_pkg::S_TUSER_W-1:0]      s_tuser,
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // wait_time, out_src_x, out_src_y, out_src_z, out_dst_x, out_dst_y,
    // out_dst_z, out_range, out_radius
    output logic [vpfd_pkg::M_TDATA_W-1:0]      m_tdata,
    // action, ack_request
    output logic [vpfd_pkg::M_TUSER_W-1:0]      m_tuser
);

    import vpfd_pkg::*;

    localparam logic [31:0] REACH_SQ   = 32'(64'(REACH) * 64'(REACH));
    localparam logic [31:0] REACH_Q16  = 32'(64'(REACH) << 16);
    localparam logic [15:0] DEF_RANGE  = 16'(DEFAULT_RANGE);
    localparam logic [15:0] DEF_RADIUS = 16'(DEFAULT_RADIUS);
    localparam int          STEP_W     = 6;
    localparam logic [STEP_W-1:0] PROD_STEPS = 6'd32;
    localparam logic [STEP_W-1:0] PROD_LAST  = 6'd33;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_PROD   = 13'b0000000000010,
        S_DECIDE = 13'b0000000000100,
        S_T1DIV  = 13'b0000000001000,
        S_T1SQ   = 13'b0000000010000,
        S_QDIV   = 13'b0000000100000,
        S_QSQ    = 13'b0000001000000,
        S_ASQ    = 13'b0000010000000,
        S_PMUL   = 13'b0000100000000,
        S_NMUL   = 13'b0001000000000,
        S_WLSQ   = 13'b0010000000000,
        S_FDIV   = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

    function automatic logic [16:0] sub17(input logic [15:0] a, input logic [15:0] b);
        return {1'b0, a} - {1'b0, b};
    endfunction

    function automatic logic signed [MUL_W-1:0] sx17(input logic [16:0] x);
        return {{(MUL_W - 17){x[16]}}, x};
    endfunction

    // control state
    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] pstep_reg;
    logic              pvalid_reg;
    logic              run_reg;
    phase_t            phase_reg;
    logic [1:0]        copy_reg;

    // configuration
    logic [15:0] node_reg [3];
    logic [15:0] goal_reg [3];
    logic [31:0] scale_reg;

    // latched event
    logic [1:0]  kind_reg;
    logic [15:0] src_reg [3];
    logic [15:0] dst_reg [3];
    logic [15:0] hop_reg [3];
    logic [15:0] rng_reg;
    logic [15:0] rad_reg;

    // held header
    logic [15:0] held_src_reg [3];
    logic [15:0] held_dst_reg [3];
    logic [15:0] held_rng_reg;
    logic [15:0] held_rad_reg;

    // accumulated products
    logic [33:0] uu_reg;
    logic [33:0] near2_reg;
    logic [31:0] rr_reg;
    logic [31:0] ra2_reg;
    logic [33:0] ng2_reg;
    logic [33:0] hg2_reg;
    logic [34:0] cx_reg;
    logic [34:0] cy_reg;
    logic [34:0] cz_reg;
    logic [67:0] cr_reg;
    logic [65:0] bnd_reg;
    logic [34:0] dot_reg;
    logic [33:0] ww_reg;
    logic [65:0] ursq_reg;
    logic [67:0] dot2_reg;

    // wait time terms
    logic [16:0] t1_reg;
    logic [33:0] q_reg;
    logic [25:0] s16_reg;
    logic [41:0] p_reg;
    logic [52:0] pm_reg;
    logic [33:0] wl_reg;

    // result
    action_t     res_act_reg;
    ack_t        res_ack_reg;
    logic [31:0] res_wait_reg;
    logic [15:0] res_hdr_reg [8];

    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [M_TUSER_W-1:0]   m_tuser_reg;

    // differences
    logic [16:0] u [3];
    logic [16:0] v [3];
    logic [16:0] w [3];
    logic [16:0] hd [3];
    logic [16:0] ng [3];
    logic [16:0] hg [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            u[k]  = sub17(dst_reg[k], src_reg[k]);
            v[k]  = sub17(node_reg[k], src_reg[k]);
            w[k]  = sub17(node_reg[k], hop_reg[k]);
            hd[k] = sub17(hop_reg[k], dst_reg[k]);
            ng[k] = sub17(node_reg[k], goal_reg[k]);
            hg[k] = sub17(hop_reg[k], goal_reg[k]);
        end
    end

    // shared multiplier operand select
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] prod;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_PMUL) begin
            mul_a = MUL_W'(s16_reg);
            mul_b = MUL_W'(scale_reg);
        end else begin
            case (step_reg)
                6'd0:  begin mul_a = sx17(u[0]);  mul_b = sx17(u[0]);  end
                6'd1:  begin mul_a = sx17(u[1]);  mul_b = sx17(u[1]);  end
                6'd2:  begin mul_a = sx17(u[2]);  mul_b = sx17(u[2]);  end
                6'd3:  begin mul_a = sx17(hd[0]); mul_b = sx17(hd[0]); end
                6'd4:  begin mul_a = sx17(hd[1]); mul_b = sx17(hd[1]); end
                6'd5:  begin mul_a = sx17(hd[2]); mul_b = sx17(hd[2]); end
                6'd6:  begin mul_a = MUL_W'(rng_reg); mul_b = MUL_W'(rng_reg); end
                6'd7:  begin mul_a = MUL_W'(rad_reg); mul_b = MUL_W'(rad_reg); end
                6'd8:  begin mul_a = sx17(ng[0]); mul_b = sx17(ng[0]); end
                6'd9:  begin mul_a = sx17(ng[1]); mul_b = sx17(ng[1]); end
                6'd10: begin mul_a = sx17(ng[2]); mul_b = sx17(ng[2]); end
                6'd11: begin mul_a = sx17(hg[0]); mul_b = sx17(hg[0]); end
                6'd12: begin mul_a = sx17(hg[1]); mul_b = sx17(hg[1]); end
                6'd13: begin mul_a = sx17(hg[2]); mul_b = sx17(hg[2]); end
                6'd14: begin mul_a = sx17(u[1]);  mul_b = sx17(v[2]);  end
                6'd15: begin mul_a = sx17(u[2]);  mul_b = sx17(v[1]);  end
                6'd16: begin mul_a = sx17(u[2]);  mul_b = sx17(v[0]);  end
                6'd17: begin mul_a = sx17(u[0]);  mul_b = sx17(v[2]);  end
                6'd18: begin mul_a = sx17(u[0]);  mul_b = sx17(v[1]);  end
                6'd19: begin mul_a = sx17(u[1]);  mul_b = sx17(v[0]);  end
                6'd20: begin mul_a = cx_reg; mul_b = cx_reg; end
                6'd21: begin mul_a = cy_reg; mul_b = cy_reg; end
                6'd22: begin mul_a = cz_reg; mul_b = cz_reg; end
                6'd23: begin mul_a = MUL_W'(uu_reg); mul_b = MUL_W'(ra2_reg); end
                6'd24: begin mul_a = sx17(u[0]);  mul_b = sx17(w[0]);  end
                6'd25: begin mul_a = sx17(u[1]);  mul_b = sx17(w[1]);  end
                6'd26: begin mul_a = sx17(u[2]);  mul_b = sx17(w[2]);  end
                6'd27: begin mul_a = sx17(w[0]);  mul_b = sx17(w[0]);  end
                6'd28: begin mul_a = sx17(w[1]);  mul_b = sx17(w[1]);  end
                6'd29: begin mul_a = sx17(w[2]);  mul_b = sx17(w[2]);  end
                6'd30: begin mul_a = MUL_W'(uu_reg); mul_b = MUL_W'(REACH_SQ); end
                6'd31: begin mul_a = dot_reg; mul_b = dot_reg; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    vpfd_mul #(.W(MUL_W)) u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // wait time terms built from the roots
    logic [35:0] a_val;
    logic [54:0] num_val;

    always_comb begin
        a_val   = 36'(t1_reg) + 36'(65536)
                + (dot_reg[34] ? 36'(q_reg) : (36'(0) - 36'(q_reg)));
        num_val = 55'(pm_reg) + 55'(REACH_Q16) - 55'(wl_reg);
    end

    // shared divider and root unit requests
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic                 sq_start;
    logic [SQ_IN_W-1:0]   sq_in;
    logic                 sq_done;
    logic [SQ_IN_W/2-1:0] sq_root;

    always_comb begin
        div_start = 1'b0;
        div_num   = {cr_reg, 32'b0};
        div_den   = bnd_reg;
        sq_start  = 1'b0;
        sq_in     = div_quo[SQ_IN_W-1:0];
        unique case (state_reg)
            S_T1DIV: begin
                div_start = !run_reg && (rad_reg != '0);
            end
            S_QDIV: begin
                div_start = !run_reg;
                div_num   = {dot2_reg, 32'b0};
                div_den   = ursq_reg;
            end
            S_FDIV: begin
                div_start = !run_reg && !num_val[54];
                div_num   = DIV_NUM_W'(num_val[53:0]);
                div_den   = DIV_DEN_W'(SOUND_SPEED);
            end
            S_T1SQ, S_QSQ: begin
                sq_start = !run_reg;
            end
            S_ASQ: begin
                sq_start = !run_reg;
                sq_in    = a_val[35] ? '0 : SQ_IN_W'({a_val[34:0], 16'b0});
            end
            S_WLSQ: begin
                sq_start = !run_reg;
                sq_in    = SQ_IN_W'({ww_reg, 32'b0});
            end
            S_IDLE, S_PROD, S_DECIDE, S_PMUL, S_NMUL, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    vpfd_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    vpfd_sqrt #(.IN_W(SQ_IN_W)) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .rad_in  (sq_in),
        .done    (sq_done),
        .root    (sq_root)
    );

    // decision terms
    logic at_target;
    logic same_hdr;
    logic drop_hdr;

    always_comb begin
        at_target = 1'b1;
        same_hdr  = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (dst_reg[k] != node_reg[k]) at_target = 1'b0;
            if (src_reg[k] != held_src_reg[k] || dst_reg[k] != held_dst_reg[k]) begin
                same_hdr = 1'b0;
            end
        end
        drop_hdr = (near2_reg <= 34'(rr_reg)) || (uu_reg == '0)
                || (cr_reg > 68'(bnd_reg)) || (ng2_reg >= hg2_reg);
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                node_reg[k] <= 16'd0;
                goal_reg[k] <= 16'd1;
            end
            scale_reg <= 32'd11410;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NODE_X: node_reg[0] <= cfg_data[15:0];
                CFG_NODE_Y: node_reg[1] <= cfg_data[15:0];
                CFG_NODE_Z: node_reg[2] <= cfg_data[15:0];
                CFG_GOAL_X: goal_reg[0] <= cfg_data[15:0];
                CFG_GOAL_Y: goal_reg[1] <= cfg_data[15:0];
                CFG_GOAL_Z: goal_reg[2] <= cfg_data[15:0];
                CFG_SCALE:  scale_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // product accumulation, in the cycle after the issue step
    always_ff @(posedge aclk) begin
        pstep_reg <= step_reg;
        if (pvalid_reg) begin
            case (pstep_reg)
                6'd0:  uu_reg    <= prod[33:0];
                6'd1,
                6'd2:  uu_reg    <= uu_reg + prod[33:0];
                6'd3:  near2_reg <= prod[33:0];
                6'd4,
                6'd5:  near2_reg <= near2_reg + prod[33:0];
                6'd6:  rr_reg    <= prod[31:0];
                6'd7:  ra2_reg   <= prod[31:0];
                6'd8:  ng2_reg   <= prod[33:0];
                6'd9,
                6'd10: ng2_reg   <= ng2_reg + prod[33:0];
                6'd11: hg2_reg   <= prod[33:0];
                6'd12,
                6'd13: hg2_reg   <= hg2_reg + prod[33:0];
                6'd14: cx_reg    <= prod[34:0];
                6'd15: cx_reg    <= cx_reg - prod[34:0];
                6'd16: cy_reg    <= prod[34:0];
                6'd17: cy_reg    <= cy_reg - prod[34:0];
                6'd18: cz_reg    <= prod[34:0];
                6'd19: cz_reg    <= cz_reg - prod[34:0];
                6'd20: cr_reg    <= 68'(prod[65:0]);
                6'd21,
                6'd22: cr_reg    <= cr_reg + 68'(prod[65:0]);
                6'd23: bnd_reg   <= prod[65:0];
                6'd24: dot_reg   <= prod[34:0];
                6'd25,
                6'd26: dot_reg   <= dot_reg + prod[34:0];
                6'd27: ww_reg    <= prod[33:0];
                6'd28,
                6'd29: ww_reg    <= ww_reg + prod[33:0];
                6'd30: ursq_reg  <= prod[65:0];
                6'd31: dot2_reg  <= prod[67:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            pvalid_reg   <= 1'b0;
            run_reg      <= 1'b0;
            phase_reg    <= PH_IDLE;
            copy_reg     <= 2'd1;
            m_tvalid_reg <= 1'b0;
        end else begin
            pvalid_reg <= 1'b0;
            // the result stage reloads the output word itself
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg <= s_tuser;
                        for (int k = 0; k < 3; k++) begin
                            src_reg[k] <= s_tdata[16*k +: 16];
                            dst_reg[k] <= s_tdata[16*(k+3) +: 16];
                            hop_reg[k] <= s_tdata[16*(k+6) +: 16];
                        end
                        rng_reg  <= s_tdata[159:144];
                        rad_reg  <= s_tdata[175:160];
                        step_reg <= '0;
                        if (s_tuser == KIND_RX && phase_reg == PH_IDLE) begin
                            state_reg <= S_PROD;
                        end else begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_PROD: begin
                    pvalid_reg <= step_reg < PROD_STEPS;
                    step_reg   <= step_reg + 1'b1;
                    if (step_reg == PROD_LAST) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    res_act_reg  <= ACT_IGNORE;
                    res_ack_reg  <= ACK_NONE;
                    res_wait_reg <= '0;
                    for (int k = 0; k < 8; k++) res_hdr_reg[k] <= '0;
                    state_reg <= S_DONE;
                    priority if (kind_reg == KIND_ORIG) begin
                        if (phase_reg != PH_IDLE) begin
                            res_act_reg <= ACT_DEFER;
                        end else begin
                            res_act_reg <= ACT_ORIG;
                            for (int k = 0; k < 3; k++) begin
                                res_hdr_reg[k]   <= node_reg[k];
                                res_hdr_reg[k+3] <= goal_reg[k];
                            end
                            res_hdr_reg[6] <= DEF_RANGE;
                            res_hdr_reg[7] <= DEF_RADIUS;
                        end
                    end else if (kind_reg == KIND_RX) begin
                        if (phase_reg != PH_IDLE) begin
                            if (!same_hdr) begin
                                res_act_reg <= ACT_DEFER;
                            end else begin
                                res_act_reg <= ACT_COPY;
                                if (phase_reg == PH_WAIT) begin
                                    phase_reg <= PH_REEVAL;
                                end else if (copy_reg != 2'd3) begin
                                    copy_reg <= copy_reg + 1'b1;
                                end
                            end
                        end else if (at_target) begin
                            res_act_reg <= ACT_DELIVER;
                            res_ack_reg <= ACK_YES;
                        end else if (drop_hdr) begin
                            res_act_reg <= ACT_DROP;
                            res_ack_reg <= ACK_NO;
                        end else begin
                            // hold the header and work out the wait time
                            res_act_reg <= ACT_HOLD;
                            for (int k = 0; k < 3; k++) begin
                                held_src_reg[k] <= src_reg[k];
                                held_dst_reg[k] <= dst_reg[k];
                            end
                            held_rng_reg <= rng_reg;
                            held_rad_reg <= rad_reg;
                            phase_reg    <= PH_WAIT;
                            copy_reg     <= 2'd1;
                            t1_reg       <= '0;
                            run_reg      <= 1'b0;
                            state_reg    <= S_T1DIV;
                        end
                    end else if (kind_reg == KIND_TIMER && phase_reg != PH_IDLE) begin
                        if (phase_reg == PH_REEVAL && copy_reg > 2'd2) begin
                            res_act_reg <= ACT_DROP;
                            res_ack_reg <= ACK_NO;
                        end else begin
                            res_act_reg <= ACT_FORWARD;
                            res_ack_reg <= ACK_YES;
                            for (int k = 0; k < 3; k++) begin
                                res_hdr_reg[k]   <= held_src_reg[k];
                                res_hdr_reg[k+3] <= held_dst_reg[k];
                            end
                            res_hdr_reg[6] <= held_rng_reg;
                            res_hdr_reg[7] <= held_rad_reg;
                        end
                        phase_reg <= PH_IDLE;
                    end else begin
                        res_act_reg <= ACT_IGNORE;
                    end
                end
                S_T1DIV: begin
                    if (!run_reg) begin
                        if (rad_reg == '0) begin
                            state_reg <= S_QDIV;
                        end else begin
                            run_reg <= 1'b1;
                        end
                    end else if (div_done) begin
                        run_reg   <= 1'b0;
                        state_reg <= S_T1SQ;
                    end
                end
                S_T1SQ: begin
                    if (!run_reg) begin
                        run_reg <= 1'b1;
                    end else if (sq_done) begin
                        t1_reg    <= sq_root[16:0];
                        run_reg   <= 1'b0;
                        state_reg <= S_QDIV;
                    end
                end
                S_QDIV: begin
                    if (!run_reg) begin
                        run_reg <= 1'b1;
                    end else if (div_done) begin
                        run_reg   <= 1'b0;
                        state_reg <= S_QSQ;
                    end
                end
                S_QSQ: begin
                    if (!run_reg) begin
                        run_reg <= 1'b1;
                    end else if (sq_done) begin
                        q_reg     <= sq_root[33:0];
                        run_reg   <= 1'b0;
                        state_reg <= S_ASQ;
                    end
                end
                S_ASQ: begin
                    if (!run_reg) begin
                        run_reg <= 1'b1;
                    end else if (sq_done) begin
                        s16_reg   <= sq_root[25:0];
                        run_reg   <= 1'b0;
                        state_reg <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    // product lands in the cycle after issue
                    if (!run_reg) begin
                        run_reg <= 1'b1;
                    end else begin
                        p_reg     <= prod[57:16];
                        run_reg   <= 1'b0;
                        state_reg <= S_NMUL;
                    end
                end
                S_NMUL: begin
                    pm_reg    <= 53'(p_reg) * 53'(SOUND_SPEED);
                    state_reg <= S_WLSQ;
                end
                S_WLSQ: begin
                    if (!run_reg) begin
                        run_reg <= 1'b1;
                    end else if (sq_done) begin
                        wl_reg    <= sq_root[33:0];
                        run_reg   <= 1'b0;
                        state_reg <= S_FDIV;
                    end
                end
                S_FDIV: begin
                    if (!run_reg) begin
                        if (num_val[54]) begin
                            res_wait_reg <= '0;
                            state_reg    <= S_DONE;
                        end else begin
                            run_reg <= 1'b1;
                        end
                    end else if (div_done) begin
                        // saturate the wait time at the top of the range
                        res_wait_reg <= (div_quo[DIV_NUM_W-1:32] != '0) ? '1 : div_quo[31:0];
                        run_reg      <= 1'b0;
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= {res_ack_reg, res_act_reg};
                        m_tdata_reg  <= {res_hdr_reg[7], res_hdr_reg[6], res_hdr_reg[5],
                                         res_hdr_reg[4], res_hdr_reg[3], res_hdr_reg[2],
                                         res_hdr_reg[1], res_hdr_reg[0], res_wait_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== bench/tb_vector_pipe_forward_decision.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_pipe_forward_decision
// Self-checking bench for the vector pipe forwarding decision block.
// ----------------------------------------------------------------------------
// A short directed table walks every event kind and every drop reason, the
// copy counter up to saturation and each timeout outcome. Random hold
// sequences with duplicates, foreign headers and timeouts follow, mixed with
// fully random words, under several register settings. A behavioral model of
// the decision predicts each result word, but for table rows that carry their
// own expected action and acknowledge; results are compared field by field as
// they leave the block. Sender gaps and receiver stalls vary between phases.
module tb_vector_pipe_forward_decision;
    import vpfd_pkg::*;

    localparam int REACH_M   = 1000;
    localparam int RANGE_DEF = 800;
    localparam int RADIUS_DEF = 350;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 600;

    // field slots inside the event word
    localparam int F_SX = 0, F_SY = 1, F_SZ = 2, F_DX = 3, F_DY = 4, F_DZ = 5;
    localparam int F_HX = 6, F_HY = 7, F_HZ = 8, F_RNG = 9, F_RAD = 10;

    typedef struct {
        action_t        act;
        ack_t           ack;
        logic [159:0]   body;   // wait_time, then the sent header fields
    } decision_t;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] sx, sy, sz, dx, dy, dz, hx, hy, hz, rng, rad;
        bit          typed;
        action_t     act;
        ack_t        ack;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    vector_pipe_forward_decision DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // model copy of registers and state
    logic [15:0] my_node [3];
    logic [15:0] my_goal [3];
    logic [31:0] my_scale;
    phase_t      my_phase;
    logic [47:0] held_src, held_dst;
    logic [15:0] held_rng, held_rad;
    int          copies;

    decision_t pending_decisions[$];
    int errors = 0;
    int words_sent = 0;
    int act_seen [8];
    int src_idle_pct = 38;
    int dst_stall_pct = 69;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // arithmetic helpers of the predictor
    // ------------------------------------------------------------------
    function automatic logic [127:0] mag(input longint v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    function automatic logic [63:0] isqrt(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] cc;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            cc = {64'd0, c} * {64'd0, c};
            if (cc <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic [127:0] sqdist(input longint ax, ay, az, bx, by, bz);
        return mag(ax - bx) * mag(ax - bx) + mag(ay - by) * mag(ay - by)
             + mag(az - bz) * mag(az - bz);
    endfunction

    function automatic logic [15:0] fld(input logic [175:0] d, input int i);
        return d[16*i +: 16];
    endfunction

    // wait time of a header that is held
    function automatic logic [31:0] hold_time(input longint s[3], d[3], h[3],
                                              input logic [15:0] rad);
        longint ux, uy, uz, vx, vy, vz, wx, wy, wz, cx, cy, cz, dot, a, num, res;
        logic [127:0] cr, uu, ra2, t1, q, s16, p, wl;
        ux = d[0] - s[0]; uy = d[1] - s[1]; uz = d[2] - s[2];
        vx = longint'(my_node[0]) - s[0]; vy = longint'(my_node[1]) - s[1];
        vz = longint'(my_node[2]) - s[2];
        wx = longint'(my_node[0]) - h[0]; wy = longint'(my_node[1]) - h[1];
        wz = longint'(my_node[2]) - h[2];
        cx = uy * vz - uz * vy; cy = uz * vx - ux * vz; cz = ux * vy - uy * vx;
        cr = mag(cx) * mag(cx) + mag(cy) * mag(cy) + mag(cz) * mag(cz);
        uu = mag(ux) * mag(ux) + mag(uy) * mag(uy) + mag(uz) * mag(uz);
        dot = ux * wx + uy * wy + uz * wz;
        ra2 = 128'(rad) * 128'(rad);
        t1 = 0;
        q = 0;
        if (rad != 0 && uu != 0) t1 = isqrt((cr << 32) / (uu * ra2));
        if (uu != 0) q = isqrt(((mag(dot) * mag(dot)) << 32) / (uu * 128'(REACH_M * REACH_M)));
        a = longint'(t1) + 65536 - ((dot >= 0) ? longint'(q) : -longint'(q));
        if (a < 0) a = 0;
        s16 = isqrt(128'(a) << 16);
        p = (s16 * 128'(my_scale)) >> 16;
        wl = isqrt(sqdist(my_node[0], my_node[1], my_node[2], h[0], h[1], h[2]) << 32);
        num = longint'(p) * SOUND_SPEED + longint'(REACH_M) * 65536 - longint'(wl);
        if (num < 0) return 32'd0;
        res = num / SOUND_SPEED;
        return (res > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : res[31:0];
    endfunction

    // ------------------------------------------------------------------
    // decision predictor, updates the model state
    // ------------------------------------------------------------------
    function automatic decision_t predict_decision(input logic [1:0] kind,
                                                   input logic [175:0] d);
        decision_t r;
        longint s[3], t[3], h[3];
        longint ux, uy, uz, vx, vy, vz, cx, cy, cz;
        logic [127:0] cr, uu, rng, rad;
        logic [47:0] w0, w1;
        r.act = ACT_IGNORE;
        r.ack = ACK_NONE;
        r.body = '0;
        for (int k = 0; k < 3; k++) begin
            s[k] = fld(d, F_SX + k);
            t[k] = fld(d, F_DX + k);
            h[k] = fld(d, F_HX + k);
        end
        rng = fld(d, F_RNG);
        rad = fld(d, F_RAD);
        w0 = d[47:0];
        w1 = d[95:48];
        case (kind)
            KIND_ORIG: begin
                if (my_phase != PH_IDLE) begin
                    r.act = ACT_DEFER;
                end else begin
                    r.act = ACT_ORIG;
                    r.body = {16'(RADIUS_DEF), 16'(RANGE_DEF), my_goal[2], my_goal[1],
                              my_goal[0], my_node[2], my_node[1], my_node[0], 32'd0};
                end
            end
            KIND_RX: begin
                if (my_phase != PH_IDLE) begin
                    if (held_src != w0 || held_dst != w1) begin
                        r.act = ACT_DEFER;
                    end else begin
                        if (my_phase == PH_WAIT) my_phase = PH_REEVAL;
                        else if (copies < 3) copies++;
                        r.act = ACT_COPY;
                    end
                end else if (t[0] == my_node[0] && t[1] == my_node[1] && t[2] == my_node[2]) begin
                    r.act = ACT_DELIVER;
                    r.ack = ACK_YES;
                end else begin
                    r.act = ACT_DROP;
                    r.ack = ACK_NO;
                    ux = t[0] - s[0]; uy = t[1] - s[1]; uz = t[2] - s[2];
                    vx = longint'(my_node[0]) - s[0]; vy = longint'(my_node[1]) - s[1];
                    vz = longint'(my_node[2]) - s[2];
                    cx = uy * vz - uz * vy; cy = uz * vx - ux * vz; cz = ux * vy - uy * vx;
                    cr = mag(cx) * mag(cx) + mag(cy) * mag(cy) + mag(cz) * mag(cz);
                    uu = sqdist(t[0], t[1], t[2], s[0], s[1], s[2]);
                    if (sqdist(h[0], h[1], h[2], t[0], t[1], t[2]) <= rng * rng) begin
                        // last forwarder already near the target
                    end else if (uu == 0 || cr > uu * rad * rad) begin
                        // outside the pipe
                    end else if (sqdist(my_node[0], my_node[1], my_node[2],
                                        my_goal[0], my_goal[1], my_goal[2]) >=
                                 sqdist(h[0], h[1], h[2], my_goal[0], my_goal[1], my_goal[2])) begin
                        // not closer to the goal
                    end else begin
                        r.act = ACT_HOLD;
                        r.ack = ACK_NONE;
                        r.body[31:0] = hold_time(s, t, h, rad[15:0]);
                        held_src = w0;
                        held_dst = w1;
                        held_rng = rng[15:0];
                        held_rad = rad[15:0];
                        my_phase = PH_WAIT;
                        copies = 1;
                    end
                end
            end
            KIND_TIMER: begin
                if (my_phase != PH_IDLE) begin
                    if (my_phase == PH_REEVAL && copies > 2) begin
                        r.act = ACT_DROP;
                        r.ack = ACK_NO;
                    end else begin
                        r.act = ACT_FORWARD;
                        r.ack = ACK_YES;
                        r.body = {held_rad, held_rng, held_dst, held_src, 32'd0};
                    end
                    my_phase = PH_IDLE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result monitor and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        decision_t want;
        logic [15:0] got_f, want_f;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_decisions.size() == 0) begin
                $display("%0t: unexpected result word, actual %h / %h", $time, m_tuser, m_tdata);
                errors++;
            end else begin
                want = pending_decisions.pop_front();
                act_seen[m_tuser[2:0]]++;
                if (m_tuser[2:0] != want.act) begin
                    $display("%0t: action expected %0d actual %0d", $time, want.act, m_tuser[2:0]);
                    errors++;
                end
                if (m_tuser[4:3] != want.ack) begin
                    $display("%0t: ack expected %0d actual %0d", $time, want.ack, m_tuser[4:3]);
                    errors++;
                end
                if (m_tdata[31:0] != want.body[31:0]) begin
                    $display("%0t: wait_time expected %h actual %h", $time,
                             want.body[31:0], m_tdata[31:0]);
                    errors++;
                end
                for (int i = 0; i < 8; i++) begin
                    got_f = m_tdata[32 + 16*i +: 16];
                    want_f = want.body[32 + 16*i +: 16];
                    if (got_f != want_f) begin
                        $display("%0t: header field %0d expected %h actual %h", $time,
                                 i, want_f, got_f);
                        errors++;
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= dst_stall_pct);
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    task automatic send_word(input logic [1:0] kind, input logic [175:0] d,
                             input bit typed, input action_t act, input ack_t ack);
        decision_t r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_decision(kind, d);
        if (typed) begin
            r.act = act;
            r.ack = ack;
            r.body = '0;
        end
        pending_decisions.push_back(r);
        words_sent++;
    endtask

    // stop sending and let every result come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_decisions.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write all registers, block idle
    task automatic program_regs(input logic [15:0] nx, ny, nz, gx, gy, gz,
                                input logic [31:0] scale);
        logic [31:0] vals [7];
        vals = '{nx, ny, nz, gx, gy, gz, scale};
        for (int i = 0; i < 7; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        my_node = '{nx, ny, nz};
        my_goal = '{gx, gy, gz};
        my_scale = scale;
    endtask

    function automatic logic [15:0] clip(input longint v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic logic [175:0] pack_row(input row_t r);
        return {r.rad, r.rng, r.hz, r.hy, r.hx, r.dz, r.dy, r.dx, r.sz, r.sy, r.sx};
    endfunction

    // well-formed header heading from behind this node toward the goal
    function automatic logic [175:0] aimed_header();
        logic [15:0] f [11];
        logic [175:0] d;
        longint dir, j;
        for (int k = 0; k < 3; k++) begin
            dir = longint'(my_goal[k]) - longint'(my_node[k]);
            j = $urandom_range(40);
            f[F_SX + k] = clip(longint'(my_node[k]) - dir / 2 + j - 20);
            f[F_DX + k] = ($urandom_range(3) != 0) ? my_goal[k]
                        : clip(longint'(my_goal[k]) + j - 20);
            f[F_HX + k] = clip(longint'(my_node[k]) - dir / 4 - 1 - j);
        end
        f[F_RNG] = $urandom_range(300);
        f[F_RAD] = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(5000));
        for (int i = 0; i < 11; i++) d[16*i +: 16] = f[i];
        return d;
    endfunction

    function automatic logic [175:0] noise_header();
        logic [175:0] d;
        for (int i = 0; i < 11; i++) d[16*i +: 16] = 16'($urandom);
        return d;
    endfunction

    // one hold attempt with events while waiting, then the timeout
    task automatic hold_sequence();
        logic [175:0] hdr, d;
        int n;
        hdr = aimed_header();
        send_word(KIND_RX, hdr, 0, ACT_IGNORE, ACK_NONE);
        n = $urandom_range(5);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(5))
                0, 1, 2: begin
                    // duplicate: same origin and target, other fields free
                    d = noise_header();
                    d[95:0] = hdr[95:0];
                end
                3: begin
                    d = hdr;
                    d[$urandom_range(95)] ^= 1'b1;
                end
                default: d = noise_header();
            endcase
            send_word(($urandom_range(4) == 0) ? KIND_ORIG : KIND_RX, d, 0, ACT_IGNORE, ACK_NONE);
        end
        send_word(KIND_TIMER, noise_header(), 0, ACT_IGNORE, ACK_NONE);
    endtask

    // ------------------------------------------------------------------
    // directed table, reset register values
    // ------------------------------------------------------------------
    row_t dir_rows [25];

    initial begin
        dir_rows = '{
            // idle timeout and spare kind are ignored
            '{KIND_TIMER, 0,0,0, 0,0,0, 0,0,0, 0,0, 1, ACT_IGNORE, ACK_NONE},
            '{KIND_ORIG, 16'hFFFF,16'hFFFF,16'hFFFF, 16'hFFFF,16'hFFFF,16'hFFFF,
              16'hFFFF,16'hFFFF,16'hFFFF, 16'hFFFF,16'hFFFF, 0, ACT_IGNORE, ACK_NONE},
            '{KIND_SPARE, 16'hFFFF,16'hFFFF,16'hFFFF, 16'hFFFF,16'hFFFF,16'hFFFF,
              16'hFFFF,16'hFFFF,16'hFFFF, 16'hFFFF,16'hFFFF, 1, ACT_IGNORE, ACK_NONE},
            // this node is the target
            '{KIND_RX, 5,5,5, 0,0,0, 9,9,9, 0,0, 1, ACT_DELIVER, ACK_YES},
            // last forwarder at the target
            '{KIND_RX, 0,0,9, 500,0,0, 500,0,0, 0,16'hFFFF, 1, ACT_DROP, ACK_NO},
            // origin equal to target
            '{KIND_RX, 300,300,300, 300,300,300, 16'hFFFF,16'hFFFF,16'hFFFF,
              0,16'hFFFF, 1, ACT_DROP, ACK_NO},
            // outside a zero-radius pipe
            '{KIND_RX, 1000,1000,0, 2000,1000,0, 16'hFFFF,16'hFFFF,16'hFFFF,
              0,0, 1, ACT_DROP, ACK_NO},
            // forwarder sits on the goal, node is not closer
            '{KIND_RX, 16'hFFFF,0,0, 100,0,0, 1,1,1, 0,0, 1, ACT_DROP, ACK_NO},
            // hold, then copies up to saturation and a drop at timeout
            '{KIND_RX, 16'hFFFF,0,0, 100,0,0, 16'hFFFF,16'hFFFF,16'hFFFF,
              0,16'hFFFF, 0, ACT_IGNORE, ACK_NONE},
            '{KIND_RX, 16'hFFFF,0,0, 100,0,0, 0,0,0, 16'hFFFF,0, 1, ACT_COPY, ACK_NONE},
            '{KIND_RX, 16'hFFFF,0,0, 100,0,0, 0,0,0, 16'hFFFF,0, 1, ACT_COPY, ACK_NONE},
            '{KIND_RX, 16'hFFFF,0,0, 100,0,0, 0,0,0, 16'hFFFF,0, 1, ACT_COPY, ACK_NONE},
            '{KIND_RX, 16'hFFFF,0,0, 100,0,0, 0,0,0, 16'hFFFF,0, 1, ACT_COPY, ACK_NONE},
            '{KIND_RX, 16'hFFFE,0,0, 100,0,0, 0,0,0, 0,0, 1, ACT_DEFER, ACK_NONE},
            '{KIND_ORIG, 0,0,0, 0,0,0, 0,0,0, 0,0, 1, ACT_DEFER, ACK_NONE},
            '{KIND_TIMER, 0,0,0, 0,0,0, 0,0,0, 0,0, 1, ACT_DROP, ACK_NO},
            // hold with zero radius, plain timeout forwards
            '{KIND_RX, 16'hFFFF,0,0, 100,0,0, 16'hFFFF,0,0, 0,0, 0, ACT_IGNORE, ACK_NONE},
            '{KIND_TIMER, 0,0,0, 0,0,0, 0,0,0, 0,0, 0, ACT_IGNORE, ACK_NONE},
            // one copy heard still forwards
            '{KIND_RX, 16'hFFFF,0,0, 100,0,0, 16'hFFFF,16'hFFFF,16'hFFFF,
              0,16'hFFFF, 0, ACT_IGNORE, ACK_NONE},
            '{KIND_RX, 16'hFFFF,0,0, 100,0,0, 7,7,7, 3,3, 1, ACT_COPY, ACK_NONE},
            '{KIND_TIMER, 0,0,0, 0,0,0, 0,0,0, 0,0, 0, ACT_IGNORE, ACK_NONE},
            // spare kind while waiting
            '{KIND_RX, 16'hFFFF,0,0, 100,0,0, 16'hFFFF,16'hFFFF,16'hFFFF,
              0,16'hFFFF, 0, ACT_IGNORE, ACK_NONE},
            '{KIND_SPARE, 0,0,0, 0,0,0, 0,0,0, 0,0, 1, ACT_IGNORE, ACK_NONE},
            '{KIND_TIMER, 0,0,0, 0,0,0, 0,0,0, 0,0, 0, ACT_IGNORE, ACK_NONE},
            '{KIND_TIMER, 0,0,0, 0,0,0, 0,0,0, 0,0, 1, ACT_IGNORE, ACK_NONE}
        };
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int quota;
        logic [15:0] nx, ny, nz;
        logic [31:0] scale;
        my_node = '{16'd0, 16'd0, 16'd0};
        my_goal = '{16'd1, 16'd1, 16'd1};
        my_scale = 32'd11410;
        my_phase = PH_IDLE;
        held_src = '0;
        held_dst = '0;
        held_rng = '0;
        held_rad = '0;
        copies = 1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].kind, pack_row(dir_rows[i]), dir_rows[i].typed,
                      dir_rows[i].act, dir_rows[i].ack);
        drain_results();

        for (int m = 0; m < 3; m++) begin
            src_idle_pct = (m == 0) ? 38 : (m == 1) ? 69 : 0;
            dst_stall_pct = (m == 0) ? 69 : (m == 1) ? 38 : 0;
            for (int setting = 0; setting < 2; setting++) begin
                // node mid-field, or pushed to an edge with an extreme scale
                case ((m * 2 + setting) % 3)
                    0: begin nx = $urandom_range(15000, 50000); ny = $urandom_range(15000, 50000);
                       nz = $urandom_range(15000, 50000); scale = $urandom; end
                    1: begin nx = 0; ny = $urandom_range(3000); nz = 16'hFFFF; scale = 0; end
                    default: begin nx = 16'hFFFF; ny = 16'hFFFF; nz = $urandom_range(3000);
                       scale = 32'hFFFF_FFFF; end
                endcase
                program_regs(nx, ny, nz,
                             clip(longint'(nx) + $urandom_range(10000) - 5000),
                             clip(longint'(ny) + $urandom_range(10000) - 5000),
                             clip(longint'(nz) + $urandom_range(10000) - 5000), scale);
                quota = words_sent + 165;
                while (words_sent < quota) begin
                    if ($urandom_range(3) == 0)
                        send_word(2'($urandom), noise_header(), 0, ACT_IGNORE, ACK_NONE);
                    else
                        hold_sequence();
                    // hold-off until the block has answered everything
                    if (m == 1 && setting == 0 && words_sent > quota - 80
                        && words_sent < quota - 70) begin
                        s_tvalid <= 1'b0;
                        @(posedge aclk);
                        wait (pending_decisions.size() == 0);
                    end
                end
                drain_results();
            end
        end

        $display("covered %0d words: %0d holds, %0d forwards, %0d drops, %0d copies,",
                 words_sent, act_seen[ACT_HOLD], act_seen[ACT_FORWARD],
                 act_seen[ACT_DROP], act_seen[ACT_COPY]);
        $display("  %0d deferred, %0d originated, %0d delivered, %0d ignored; %0d errors",
                 act_seen[ACT_DEFER], act_seen[ACT_ORIG], act_seen[ACT_DELIVER],
                 act_seen[ACT_IGNORE], errors);
        if (errors == 0 && pending_decisions.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #200ms;
        $display("timeout with %0d results outstanding", pending_decisions.size());
        $display("Verification failed");
        $finish;
    end

endmodule
